/* hdl/pli_pkg.sv */
// Package for the positional list block: request and response payload types,
// command and status structs between controller and datapath, and codes.
// No dependencies.
package pli_pkg;

	localparam int CAPACITY_DEF = 32;

	// Request modes.
	localparam logic [1:0] MODE_INS = 2'd0;
	localparam logic [1:0] MODE_DEL = 2'd1;
	localparam logic [1:0] MODE_RD  = 2'd2;

	// Response status codes.
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [5:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] word_out;
		logic [5:0]         count;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;
		logic step;
		logic drain;
		logic put;
		logic res_load;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic chk_ok;
		logic chk_nomove;
		logic ins;
		logic last;
	} dp_stat_t;

endpackage

/* hdl/pli_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/pli_dp.sv */
// Datapath of the positional list: entry count, request registers, the move
// pipeline over the list RAM and the response register.
// Depends on pli_pkg and pli_ram.
module pli_dp #(
	parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pli_pkg::req_t     req,
	input  pli_pkg::dp_cmd_t  cmd,
	output pli_pkg::dp_stat_t stat,
	output pli_pkg::rsp_t     rsp
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 6 ? CW : 6) + 1;

	logic [CW-1:0]      count_q;
	logic [1:0]         mode_q;
	logic [1:0]         status_q;
	logic [AW-1:0]      idx_q;
	logic signed [31:0] value_q;
	logic signed [31:0] word_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [CW-1:0]      remain_q;
	logic               mv_vld_s1;
	logic               mv_cap_s1;
	logic [AW-1:0]      mv_addr_s1;
	pli_pkg::rsp_t      rsp_q;

	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] n_x;
	logic [CMPW-1:0] moves_x;
	logic [1:0]      chk_status;
	logic [CW-1:0]   remain_init;
	logic [AW-1:0]   ptr_init;
	logic            is_ins;
	logic            cap_now;
	logic [CW+5:0]   cnt_ext;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [31:0]     ram_wdata;
	logic [31:0]     ram_rdata;

	assign pos_x   = CMPW'(req.position);
	assign n_x     = CMPW'(count_q);
	assign moves_x = n_x - pos_x + CMPW'(1);

	// Classify the request on offer against the current length.
	always_comb begin
		chk_status  = pli_pkg::ST_BADPOS;
		remain_init = CW'(moves_x);
		ptr_init    = AW'(pos_x - CMPW'(1));
		unique case (req.mode)
			pli_pkg::MODE_INS: begin
				ptr_init = AW'(n_x - CMPW'(1));
				if (pos_x != '0 && pos_x <= n_x + CMPW'(1)) begin
					chk_status = (count_q == CW'(CAPACITY)) ? pli_pkg::ST_FULL
					                                        : pli_pkg::ST_DONE;
				end
			end
			pli_pkg::MODE_DEL: begin
				if (pos_x != '0 && pos_x <= n_x) begin
					chk_status = pli_pkg::ST_DONE;
				end
			end
			pli_pkg::MODE_RD: begin
				remain_init = CW'(1);
				if (pos_x != '0 && pos_x <= n_x) begin
					chk_status = pli_pkg::ST_DONE;
				end
			end
			default: begin
				chk_status = pli_pkg::ST_BADPOS;
			end
		endcase
	end

	assign is_ins = (mode_q == pli_pkg::MODE_INS);
	// The first read of a delete or a read fetches the requested word itself.
	assign cap_now = !is_ins && (rd_ptr_q == idx_q);

	assign stat.chk_ok     = (chk_status == pli_pkg::ST_DONE);
	assign stat.chk_nomove = (remain_init == '0);
	assign stat.ins        = is_ins;
	assign stat.last       = (remain_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			mv_vld_s1 <= 1'b0;
		end else begin
			mv_vld_s1 <= cmd.step;
			if (cmd.put) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.drain && mode_q == pli_pkg::MODE_DEL) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q   <= req.mode;
			status_q <= chk_status;
			idx_q    <= AW'(pos_x - CMPW'(1));
			value_q  <= req.value;
			word_q   <= '0;
			rd_ptr_q <= ptr_init;
			remain_q <= remain_init;
		end else begin
			if (cmd.step) begin
				rd_ptr_q <= is_ins ? rd_ptr_q - AW'(1) : rd_ptr_q + AW'(1);
				remain_q <= remain_q - CW'(1);
			end
			if (mv_vld_s1 && mv_cap_s1) begin
				word_q <= ram_rdata;
			end
		end
		mv_cap_s1  <= cap_now;
		mv_addr_s1 <= is_ins ? rd_ptr_q + AW'(1) : rd_ptr_q - AW'(1);
		if (cmd.res_load) begin
			rsp_q.status   <= status_q;
			rsp_q.word_out <= word_q;
			rsp_q.count    <= cnt_ext[5:0];
		end
	end

	assign cnt_ext = {6'd0, count_q};

	assign ram_we    = cmd.put || (mv_vld_s1 && !mv_cap_s1);
	assign ram_waddr = cmd.put ? idx_q : mv_addr_s1;
	assign ram_wdata = cmd.put ? value_q : ram_rdata;

	pli_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	assign rsp = rsp_q;

	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.put && mv_vld_s1 && !mv_cap_s1))
		else $error("insert write collides with a move write");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> count_q < CW'(CAPACITY))
		else $error("insert into a full list");

	a_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> CW'(rd_ptr_q) < count_q)
		else $error("move reads beyond the list");

endmodule

/* hdl/pli_ctrl.sv */
// Controller of the positional list: request and response handshakes and the
// state machine that sequences the datapath. Depends on pli_pkg.
module pli_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  pli_pkg::dp_stat_t stat,
	output pli_pkg::dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_RUN   = 5'b00010,
		S_DRAIN = 5'b00100,
		S_PUT   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (!stat.chk_ok) begin
						state_d = S_DONE;
					end else if (stat.chk_nomove) begin
						state_d = S_PUT;
					end else begin
						state_d = S_RUN;
					end
				end
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd.drain = 1'b1;
				state_d   = stat.ins ? S_PUT : S_DONE;
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> slot_free)
		else $error("response overwritten before it was taken");

	a_run_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && stat.last) |=> state_q == S_DRAIN)
		else $error("move pipeline not drained");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q != S_IDLE)
		else $error("request accepted but not processed");

endmodule

/* hdl/positional_list_insert_delete.sv */
// Top level of the positional list: ordered list of signed words with
// insert, delete and read by 1-based position. Depends on pli_pkg, pli_ctrl, pli_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  request | req_valid, req_ready | req.mode, req.position, req.value
//  response| rsp_valid, rsp_ready | rsp.status, rsp.word_out, rsp.count
//
// One request at a time; req_ready is high only while the block is idle.
// With n entries and position p, an insert runs S_RUN over n-p+1 entries, S_DRAIN
// and S_PUT (S_PUT alone when appending); a delete or read runs S_RUN and S_DRAIN;
// a rejected request goes straight to S_DONE. The list RAM moves one entry per cycle
// in S_RUN. The next request can be taken in the cycle after the response is loaded.
// Reset clears the entry count, the state and rsp_valid; list contents are undefined until written.
// A response stalled by rsp_ready holds the next request's response in the final state.
module positional_list_insert_delete #(
	parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  pli_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pli_pkg::rsp_t rsp
);

	pli_pkg::dp_cmd_t  cmd;
	pli_pkg::dp_stat_t stat;

	pli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pli_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.stat  (stat),
		.rsp   (rsp)
	);

endmodule
